>>> rtl/ccq_pkg.sv
// Shared widths for the camera center pipeline.
// Used by the divider and by the top level; no dependencies.
package ccq_pkg;

    localparam int NUM_W = 72;
    localparam int DEN_W = 34;
    localparam int QUO_W = 34;
    localparam int NEG_W = 33;

endpackage

>>> rtl/ccq_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ccq_pkg for widths; the numerator must be below den * 2^QUO_W.
module ccq_div
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [ccq_pkg::NUM_W-1:0] num,
    input  logic [ccq_pkg::DEN_W-1:0] den,
    output logic [ccq_pkg::QUO_W-1:0] quo
);

    localparam int NW = ccq_pkg::NUM_W;
    localparam int DW = ccq_pkg::DEN_W;
    localparam int QW = ccq_pkg::QUO_W;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [NW-1:0] dsh;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign dsh = NW'(den_in) << (QW - 1 - i);
        assign ge  = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? rem_in - dsh : rem_in;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_in | (QW'(ge) << (QW - 1 - i));
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

>>> rtl/camera_center_from_quaternion_pose.sv
// Camera projection center c = -R(q)^T t from a Q2.14 quaternion and Q16.16 translation.
// Depends on ccq_pkg and ccq_div.
//
// One item enters per clock while the output is not stalled. Its result
// is presented on the output after 41 register stages: six stages of input
// capture, products and sums, the 34-stage divider with one quotient bit per
// stage, and the output register. A stall on the output holds the whole pipeline.
// Input tdata, lowest bit up: quat_w, quat_x, quat_y, quat_z (16 each),
// trans_x, trans_y, trans_z (32 each). Output tdata: center_x, center_y,
// center_z (32 each); tuser: zero_quat, saturated.
module camera_center_from_quaternion_pose
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // center_x, center_y, center_z
    output logic [1:0]   m_axis_tuser    // zero_quat, saturated
);

    localparam int NW = ccq_pkg::NUM_W;
    localparam int DW = ccq_pkg::DEN_W;
    localparam int QW = ccq_pkg::QUO_W;
    localparam int SW = ccq_pkg::NEG_W;

    logic en;
    logic [6:1] vld_reg;
    logic [QW-1:0] dv_reg;
    logic out_valid_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1
    logic signed [15:0] w1_reg, x1_reg, y1_reg, z1_reg;
    logic signed [31:0] t1_reg [3];
    // stage 2
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, wz_reg, xz_reg, wy_reg,
                        yz_reg, wx_reg;
    logic [2:0][SW-1:0] s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    // stage 3
    logic signed [35:0] m_reg [3][3];
    logic [DW-1:0]      n2_3_reg, n2_4_reg, n2_5_reg, n2_6_reg;
    logic               z3_reg, z4_reg, z5_reg, z6_reg;
    // stage 4
    logic signed [52:0] ph_reg [3][3];
    logic signed [52:0] pl_reg [3][3];
    // stage 5
    logic signed [54:0] a_reg [3];
    logic signed [54:0] b_reg [3];
    // stage 6
    logic [NW-1:0] num_reg [3];
    logic [DW-1:0] den_reg;
    // side line through divider
    logic               dz_reg [QW];
    logic [2:0][SW-1:0] ds_reg [QW];
    logic [QW-1:0]      quo [3];
    // output
    logic [95:0] out_data_reg;
    logic        out_zero_reg;
    logic        out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[5:1], s_axis_tvalid};
            dv_reg        <= {dv_reg[QW-2:0], vld_reg[6]};
            out_valid_reg <= dv_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg    <= $signed(s_axis_tdata[15:0]);
            x1_reg    <= $signed(s_axis_tdata[31:16]);
            y1_reg    <= $signed(s_axis_tdata[47:32]);
            z1_reg    <= $signed(s_axis_tdata[63:48]);
            t1_reg[0] <= $signed(s_axis_tdata[95:64]);
            t1_reg[1] <= $signed(s_axis_tdata[127:96]);
            t1_reg[2] <= $signed(s_axis_tdata[159:128]);

            ww_reg <= w1_reg * w1_reg;
            xx_reg <= x1_reg * x1_reg;
            yy_reg <= y1_reg * y1_reg;
            zz_reg <= z1_reg * z1_reg;
            xy_reg <= x1_reg * y1_reg;
            wz_reg <= w1_reg * z1_reg;
            xz_reg <= x1_reg * z1_reg;
            wy_reg <= w1_reg * y1_reg;
            yz_reg <= y1_reg * z1_reg;
            wx_reg <= w1_reg * x1_reg;
            for (int j = 0; j < 3; j++)
            begin
                s2_reg[j] <= SW'(-(SW'(t1_reg[j])));
            end

            n2_3_reg <= DW'(ww_reg) + DW'(xx_reg) + DW'(yy_reg) + DW'(zz_reg);
            z3_reg   <= (ww_reg == 0) && (xx_reg == 0) && (yy_reg == 0) && (zz_reg == 0);
            s3_reg   <= s2_reg;
            m_reg[0][0] <= 36'(ww_reg) + 36'(xx_reg) - 36'(yy_reg) - 36'(zz_reg);
            m_reg[0][1] <= (36'(xy_reg) + 36'(wz_reg)) <<< 1;
            m_reg[0][2] <= (36'(xz_reg) - 36'(wy_reg)) <<< 1;
            m_reg[1][0] <= (36'(xy_reg) - 36'(wz_reg)) <<< 1;
            m_reg[1][1] <= 36'(ww_reg) - 36'(xx_reg) + 36'(yy_reg) - 36'(zz_reg);
            m_reg[1][2] <= (36'(yz_reg) + 36'(wx_reg)) <<< 1;
            m_reg[2][0] <= (36'(xz_reg) + 36'(wy_reg)) <<< 1;
            m_reg[2][1] <= (36'(yz_reg) - 36'(wx_reg)) <<< 1;
            m_reg[2][2] <= 36'(ww_reg) - 36'(xx_reg) - 36'(yy_reg) + 36'(zz_reg);

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ph_reg[i][j] <= m_reg[i][j] * $signed(s3_reg[j][SW-1:16]);
                    pl_reg[i][j] <= m_reg[i][j] * $signed({1'b0, s3_reg[j][15:0]});
                end
            end
            n2_4_reg <= n2_3_reg;
            z4_reg   <= z3_reg;
            s4_reg   <= s3_reg;

            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= 55'(ph_reg[i][0]) + 55'(ph_reg[i][1]) + 55'(ph_reg[i][2]);
                b_reg[i] <= 55'(pl_reg[i][0]) + 55'(pl_reg[i][1]) + 55'(pl_reg[i][2]);
            end
            n2_5_reg <= n2_4_reg;
            z5_reg   <= z4_reg;
            s5_reg   <= s4_reg;

            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= ((NW'(a_reg[i]) << 17) + (NW'(b_reg[i]) << 1))
                              + NW'(n2_5_reg) + (NW'(n2_5_reg) << 34);
            end
            den_reg  <= n2_5_reg << 1;
            n2_6_reg <= n2_5_reg;
            z6_reg   <= z5_reg;
            s6_reg   <= s5_reg;

            dz_reg[0] <= z6_reg;
            ds_reg[0] <= s6_reg;
            for (int k = 1; k < QW; k++)
            begin
                dz_reg[k] <= dz_reg[k-1];
                ds_reg[k] <= ds_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        ccq_div u_div
        (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    logic signed [QW-1:0] cval [3];
    logic [95:0]          cdat;
    logic [2:0]           clip;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dz_reg[QW-1])
            begin
                cval[i] = QW'($signed(ds_reg[QW-1][i]));
            end
            else
            begin
                cval[i] = $signed({~quo[i][QW-1], quo[i][QW-2:0]});
            end
            if (cval[i] > $signed(QW'(32'sh7fffffff)))
            begin
                clip[i]           = 1'b1;
                cdat[32*i +: 32]  = 32'h7fffffff;
            end
            else if (cval[i] < $signed(QW'(-34'sh80000000)))
            begin
                clip[i]           = 1'b1;
                cdat[32*i +: 32]  = 32'h80000000;
            end
            else
            begin
                clip[i]           = 1'b0;
                cdat[32*i +: 32]  = cval[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= cdat;
            out_zero_reg <= dz_reg[QW-1];
            out_sat_reg  <= |clip;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_sat_reg, out_zero_reg};

    a_zero_den : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && z6_reg |-> den_reg == '0 && n2_6_reg == '0)
        else $error("zero quaternion item carries a nonzero divisor");

    a_quo_range : assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[QW-1] && !dz_reg[QW-1] |->
            (quo[0][QW-1] ^ quo[0][QW-2]) && (quo[1][QW-1] ^ quo[1][QW-2])
            && (quo[2][QW-1] ^ quo[2][QW-2]))
        else $error("divider quotient outside offset range");

    a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000
            || m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000
            || m_axis_tdata[95:64] == 32'h7fffffff || m_axis_tdata[95:64] == 32'h80000000)
        else $error("saturated flag without a clipped component");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for camera_center_from_quaternion_pose: directed poses, then random ones.
// Depends only on the block; expected centers come from an integer predictor in this file.
module testbench;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;   // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // center_x, center_y, center_z
    logic [1:0]   m_axis_tuser;   // zero_quat, saturated

    typedef struct packed {
        logic [31:0] cz;
        logic [31:0] cy;
        logic [31:0] cx;
        logic        sat;
        logic        zq;
    } center_t;

    localparam int WATCHDOG = 5000;
    localparam int N_RAND   = 1500;
    localparam int N_DIR    = 20;

    center_t     center_q[$];
    int          mismatches;
    int          received;
    int          sent;
    int          idle_cycles;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          zero_seen;
    int          sat_seen;
    logic [159:0] dir_data[N_DIR];
    logic [97:0]  dir_exp[N_DIR];
    logic         dir_known[N_DIR];

    camera_center_from_quaternion_pose uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [127:0] fdiv(input logic signed [127:0] a,
                                                 input logic signed [127:0] d);
        logic signed [127:0] q;
        q = a / d;
        if (a % d < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] clip32(input logic signed [127:0] v, ref logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic center_t project_center(input logic [159:0] d);
        logic signed [127:0] w, x, y, z, n2;
        logic signed [127:0] s[3];
        logic signed [127:0] m[3][3];
        logic signed [127:0] c[3];
        logic signed [127:0] p;
        center_t r;
        logic sat;
        w = $signed(d[15:0]);
        x = $signed(d[31:16]);
        y = $signed(d[47:32]);
        z = $signed(d[63:48]);
        s[0] = -$signed(d[95:64]);
        s[1] = -$signed(d[127:96]);
        s[2] = -$signed(d[159:128]);
        n2 = w*w + x*x + y*y + z*z;
        sat = 1'b0;
        r.zq = (n2 == 0);
        if (n2 == 0)
        begin
            for (int i = 0; i < 3; i++)
                c[i] = s[i];
        end
        else
        begin
            m[0][0] = w*w + x*x - y*y - z*z;
            m[0][1] = 2*(x*y + w*z);
            m[0][2] = 2*(x*z - w*y);
            m[1][0] = 2*(x*y - w*z);
            m[1][1] = w*w - x*x + y*y - z*z;
            m[1][2] = 2*(y*z + w*x);
            m[2][0] = 2*(x*z + w*y);
            m[2][1] = 2*(y*z - w*x);
            m[2][2] = w*w - x*x - y*y + z*z;
            for (int i = 0; i < 3; i++)
            begin
                p = m[i][0]*s[0] + m[i][1]*s[1] + m[i][2]*s[2];
                c[i] = fdiv(2*p + n2, 2*n2);
            end
        end
        r.cx = clip32(c[0], sat);
        r.cy = clip32(c[1], sat);
        r.cz = clip32(c[2], sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [159:0] pose(input logic [15:0] w, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] z,
                                          input logic [31:0] tx, input logic [31:0] ty,
                                          input logic [31:0] tz);
        return {tz, ty, tx, z, y, x, w};
    endfunction

    function automatic logic [15:0] rand_q(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return $urandom_range(0, 3) == 0 ? 16'h4000 : 16'h0000;
            default: return 16'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [31:0] rand_t();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [159:0] d);
        while (snd_idle_pct > 0 && $urandom_range(1, 100) <= snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        center_q = {center_q, project_center(d)};
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (center_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= !(rcv_idle_pct > 0 && $urandom_range(1, 100) <= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        center_t got;
        center_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("watchdog expired after %0d items sent, %0d received", sent, received);
                $display("camera_center_from_quaternion_pose verification failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tuser[1], m_axis_tuser[0]};
                received++;
                if (center_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: %h", got);
                end
                else
                begin
                    want = center_q.pop_front();
                    zero_seen += want.zq;
                    sat_seen  += want.sat;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"item %0d: expected c=(%h %h %h) zq=%b sat=%b, ",
                                      "got c=(%h %h %h) zq=%b sat=%b"},
                                     received, want.cx, want.cy, want.cz, want.zq, want.sat,
                                     got.cx, got.cy, got.cz, got.zq, got.sat);
                    end
                end
            end
        end
    end

    initial
    begin
        center_t row_exp;
        dir_data[0]  = pose(16'h4000, 0, 0, 0, 32'h00010000, 32'h00020000, 32'hfffd0000);
        dir_exp[0]   = {32'h00030000, 32'hfffe0000, 32'hffff0000, 1'b0, 1'b0};
        dir_data[1]  = pose(0, 0, 0, 0, 32'h00050000, 32'hfff00000, 32'h12345678);
        dir_exp[1]   = {32'hedcba988, 32'h00100000, 32'hfffb0000, 1'b0, 1'b1};
        dir_data[2]  = pose(0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0);
        dir_exp[2]   = {32'h00000000, 32'h80000001, 32'h7fffffff, 1'b1, 1'b1};
        dir_data[3]  = pose(16'h4000, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
        dir_exp[3]   = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0};
        dir_data[4]  = pose(16'h8000, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        dir_exp[4]   = {32'h80000001, 32'h80000001, 32'h80000001, 1'b0, 1'b0};
        dir_data[5]  = pose(0, 16'h4000, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000);
        dir_data[6]  = pose(0, 0, 16'h4000, 0, 32'h00010000, 32'h00010000, 32'h00010000);
        dir_data[7]  = pose(0, 0, 0, 16'h4000, 32'h00010000, 32'h00010000, 32'h00010000);
        dir_data[8]  = pose(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            32'h7fffffff, 32'h80000000, 32'h7fffffff);
        dir_data[9]  = pose(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                            32'h80000000, 32'h7fffffff, 32'h80000000);
        dir_data[10] = pose(16'h0001, 0, 0, 0, 32'h00000001, 32'hffffffff, 32'h00000003);
        dir_data[11] = pose(16'h0001, 16'h0001, 0, 0, 32'h00000001, 32'h00000001, 32'h00000001);
        dir_data[12] = pose(16'h2d41, 0, 0, 16'h2d41, 32'h7fffffff, 32'h7fffffff, 0);
        dir_data[13] = pose(16'hffff, 16'h0001, 16'hffff, 16'h0001,
                            32'h00008000, 32'hffff8000, 32'h00018000);
        dir_data[14] = pose(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                            32'hffffffff, 32'hffffffff, 32'hffffffff);
        dir_data[15] = pose(16'h1234, 16'hedcb, 16'h5a5a, 16'ha5a5,
                            32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
        dir_data[16] = pose(0, 0, 0, 16'h0001, 32'h80000000, 32'h80000000, 32'h80000000);
        dir_data[17] = pose(0, 16'h7fff, 16'h8000, 0, 32'h00000000, 32'h00000000, 32'h00000000);
        dir_data[18] = pose(16'h4000, 16'h4000, 0, 0, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
        dir_data[19] = pose(16'h0003, 16'h0000, 16'h0000, 16'h0000,
                            32'h00000001, 32'h00000000, 32'hffffffff);
        for (int i = 0; i < N_DIR; i++)
            dir_known[i] = (i < 5);

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        received      = 0;
        sent          = 0;
        idle_cycles   = 0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        zero_seen     = 0;
        sat_seen      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            send_item(dir_data[i]);
            if (dir_known[i])
            begin
                row_exp = dir_exp[i];
                if (row_exp !== center_q[$])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: table %h, predictor %h",
                                 i, row_exp, center_q[$]);
                end
            end
        end
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
                1: begin snd_idle_pct = 50; rcv_idle_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_idle_pct = 50; end
                default: begin snd_idle_pct = 9; rcv_idle_pct = 9; end
            endcase
            for (int k = 0; k < N_RAND / 4; k++)
            begin
                int mode;
                mode = $urandom_range(0, 2);
                send_item(pose(rand_q(mode), rand_q(mode), rand_q(mode), rand_q(mode),
                               rand_t(), rand_t(), rand_t()));
            end
            drain();
        end
        rcv_idle_pct = 0;

        $display("sent %0d poses through four idle/stall phases; received %0d centers",
                 sent, received);
        $display("%0d with a zero quaternion, %0d saturated", zero_seen, sat_seen);
        if (mismatches == 0 && center_q.size() == 0)
            $display("camera_center_from_quaternion_pose verification clean");
        else
            $display("camera_center_from_quaternion_pose verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/ccq_pkg.sv
rtl/ccq_div.sv
rtl/camera_center_from_quaternion_pose.sv
sim/testbench.sv
